[rtl/stmf_pkg.sv]
package stmf_pkg;

  localparam int MeanBits = 20;
  localparam int UsedBits = 4;
  localparam int FracBits = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,
    S_SCAN,
    S_DIV,
    S_OUT
  } stmf_state_e;

endpackage

[rtl/stmf_if.sv]
interface stmf_in_if #(
  parameter int SampleBits = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface stmf_out_if ();
  import stmf_pkg::*;
  logic                valid;
  logic                ready;
  logic [MeanBits-1:0] trimmed_mean;
  logic [UsedBits-1:0] samples_used;

  modport source(output valid, output trimmed_mean, output samples_used, input ready);
  modport sink(input valid, input trimmed_mean, input samples_used, output ready);
endinterface

[rtl/stmf_window_mem.sv]
module stmf_window_mem #(
  parameter int Depth = 15,
  parameter int Width = 16,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AddrW-1:0] raddr_a_i,
  output logic [Width-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem[raddr_a_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_b_i) begin
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

[rtl/stmf_divider.sv]
module stmf_divider #(
  parameter int NumW = 24,
  parameter int DenW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0]   rem_q, rem_sh, rem_d;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] den_q;
  logic            bit_d;
  logic            done_q;

  assign rem_sh = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign bit_d  = rem_sh >= {1'b0, den_q};
  assign rem_d  = bit_d ? rem_sh - {1'b0, den_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NumW-2:0], bit_d};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/sliding_trimmed_mean_filter.sv]
// Sliding-window trimmed mean filter.
// in_i carries raw samples (valid/ready); out_o carries one result per
// sample: the truncated mean of the window (4 fractional bits), less the TRIM
// lowest and highest if over 2*TRIM are valid, and the count of valid entries.
// A sample is taken only while the block is idle. It is written into the
// window memory, then every valid entry is ranked against all others by a
// scan through the second read port of that memory, one comparison a cycle,
// and the kept entries are summed. A restoring divider, one quotient bit a
// cycle, forms the mean.
// The next sample is accepted once the result has been moved to the output register.
// The output register holds a result until out_o.ready; a stalled receiver
// holds the block in its final step but a new sample is still taken when the
// previous result is only waiting at the output.
// Reset empties the window: the count restarts at one and no entry is read
// before it has been written.
module sliding_trimmed_mean_filter #(
  parameter int WINDOW      = 15,
  parameter int TRIM        = 3,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  stmf_in_if.sink    in_i,
  stmf_out_if.source out_o
);
  import stmf_pkg::*;

  localparam int PW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW      = $clog2(WINDOW + 1);
  localparam int SW      = SAMPLE_BITS + CW;
  localparam int NW      = SW + FracBits;
  localparam int TwoTrim = 2 * TRIM;

  stmf_state_e state_q, state_d;

  logic [PW-1:0]          wp_q, wp_d, wp_inc;
  logic                   full_q, full_d;
  logic [CW-1:0]          count_q, count_d;
  logic [PW-1:0]          i_q, i_d, j_q, j_d;
  logic [CW-1:0]          rank_q, rank_d, rank_fin;
  logic [SW-1:0]          sum_q, sum_d;
  logic [CW-1:0]          used;
  logic                   keep, less, last_j;
  logic [SAMPLE_BITS-1:0] key, cand;
  logic                   in_acc;
  logic                   re_a, re_b;
  logic [PW-1:0]          raddr_b;
  logic                   div_start, div_done;
  logic [NW-1:0]          quo;
  logic                   out_valid_q;
  logic [MeanBits-1:0]    mean_q;
  logic [UsedBits-1:0]    used_out_q;
  logic                   out_load;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign wp_inc = (int'(wp_q) == WINDOW - 1) ? '0 : wp_q + 1'b1;

  stmf_window_mem #(
    .Depth(WINDOW),
    .Width(SAMPLE_BITS),
    .AddrW(PW)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (in_acc),
    .waddr_i  (wp_q),
    .wdata_i  (in_i.sample),
    .re_a_i   (re_a),
    .raddr_a_i(i_q),
    .rdata_a_o(key),
    .re_b_i   (re_b),
    .raddr_b_i(raddr_b),
    .rdata_b_o(cand)
  );

  // Stable rank: ties are ordered by slot index.
  assign less     = (cand < key) || ((cand == key) && (j_q < i_q));
  assign rank_fin = rank_q + CW'(less);
  assign last_j   = (CW'(j_q) == count_q - 1'b1);
  assign keep     = (int'(count_q) <= TwoTrim) ||
                    ((int'(rank_fin) >= TRIM) && (int'(rank_fin) < int'(count_q) - TRIM));
  assign used     = (int'(count_q) <= TwoTrim) ? count_q : CW'(int'(count_q) - TwoTrim);

  // The divide starts on the last scan cycle, so take the sum with the final key added.
  stmf_divider #(
    .NumW(NW),
    .DenW(CW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({sum_d, FracBits'(0)}),
    .den_i  (used),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    full_d    = full_q;
    count_d   = count_q;
    i_d       = i_q;
    j_d       = j_q;
    rank_d    = rank_q;
    sum_d     = sum_q;
    re_a      = 1'b0;
    re_b      = 1'b0;
    raddr_b   = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          wp_d   = wp_inc;
          full_d = full_q || (wp_inc == '0);
          if (full_d) begin
            count_d = CW'(WINDOW);
          end else begin
            count_d = CW'(wp_inc);
          end
          i_d     = '0;
          sum_d   = '0;
          state_d = S_KEY;
        end
      end
      S_KEY: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_b = '0;
        j_d     = '0;
        rank_d  = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        re_b    = 1'b1;
        raddr_b = j_q + 1'b1;
        j_d     = j_q + 1'b1;
        rank_d  = rank_fin;
        if (last_j) begin
          if (keep) begin
            sum_d = sum_q + SW'(key);
          end
          if (CW'(i_q) == count_q - 1'b1) begin
            state_d = S_DIV;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_KEY;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // Launch the divide as the scan completes.
    div_start = (state_q == S_SCAN) && (state_d == S_DIV);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      full_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      full_q  <= full_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    rank_q <= rank_d;
    sum_q  <= sum_d;
    if (out_load) begin
      mean_q     <= MeanBits'(quo);
      used_out_q <= UsedBits'(count_q);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.trimmed_mean = mean_q;
  assign out_o.samples_used = used_out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (count_q != '0) && (int'(count_q) <= WINDOW))
    else $error("window count out of range");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wp_q) < WINDOW)
    else $error("write pointer out of range");

  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside final step");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("window full flag dropped");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside divide step");

endmodule

[verif/sliding_trimmed_mean_filter_tb.sv]
`timescale 1ns / 100ps

module sliding_trimmed_mean_filter_tb;
  import stmf_pkg::*;

  localparam int Window     = 15;
  localparam int Trim       = 3;
  localparam int SampleBits = 16;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic [MeanBits-1:0] trimmed_mean;
    logic [UsedBits-1:0] samples_used;
  } filt_result_t;

  class mean_scoreboard;
    logic [SampleBits-1:0] ring[Window];
    int unsigned           wr_slot;
    bit                    wrapped;
    filt_result_t          pending_q[$];
    int unsigned           errors;

    function void clear();
      foreach (ring[i]) ring[i] = '0;
      wr_slot = 0;
      wrapped = 0;
      errors  = 0;
      pending_q.delete();
    endfunction

    // Update the window and queue the filtered value this sample produces.
    function void note_sample(logic [SampleBits-1:0] smp);
      logic [SampleBits-1:0] vals[$];
      logic [63:0]           acc;
      int unsigned           cnt, lo, hi;
      filt_result_t          r;
      ring[wr_slot] = smp;
      wr_slot++;
      if (wr_slot >= Window) begin
        wr_slot = 0;
        wrapped = 1;
      end
      cnt = wrapped ? Window : ((wr_slot == 0) ? 1 : wr_slot);
      for (int i = 0; i < cnt; i++) vals.push_back(ring[i]);
      vals.sort();
      if (cnt <= 2 * Trim) begin
        lo = 0;
        hi = cnt;
      end else begin
        lo = Trim;
        hi = cnt - Trim;
      end
      acc = 0;
      for (int i = lo; i < hi; i++) acc += vals[i];
      r.trimmed_mean = MeanBits'((acc << FracBits) / (hi - lo));
      r.samples_used = UsedBits'(cnt);
      pending_q.push_back(r);
    endfunction

    function void check_result(filt_result_t got);
      filt_result_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result: trimmed_mean %0d samples_used %0d",
               got.trimmed_mean, got.samples_used);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.trimmed_mean !== exp_r.trimmed_mean) begin
        $error("trimmed_mean: expected %0d, actual %0d", exp_r.trimmed_mean,
               got.trimmed_mean);
        errors++;
      end
      if (got.samples_used !== exp_r.samples_used) begin
        $error("samples_used: expected %0d, actual %0d", exp_r.samples_used,
               got.samples_used);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  stmf_in_if #(.SampleBits(SampleBits)) in_if ();
  stmf_out_if out_if ();

  sliding_trimmed_mean_filter #(
    .WINDOW     (Window),
    .TRIM       (Trim),
    .SAMPLE_BITS(SampleBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  mean_scoreboard sb;
  bit             quiet_tail;
  bit             long_hold;
  int unsigned    idle_cycles;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    out_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    quiet_tail    = 1'b0;
    long_hold     = 1'b0;
    sb            = new();
    sb.clear();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Check each output transaction.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result({out_if.trimmed_mean, out_if.samples_used});
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("** sliding_trimmed_mean_filter: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet_tail && $urandom_range(3) == 0) begin
        out_if.ready <= 1'b0;
        n = $urandom_range(16, 1);
        repeat (n) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        n = $urandom_range(24, 1);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send_sample(logic [SampleBits-1:0] smp);
    int unsigned gap;
    if (!quiet_tail && $urandom_range(3) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(16, 1);
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= smp;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(smp);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SampleBits-1:0] rand_sample();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return SampleBits'($urandom_range(15));
      3: return SampleBits'(16'hFFFF - $urandom_range(15));
      default: return SampleBits'($urandom);
    endcase
  endfunction

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    // Startup with few entries, extremes, then wrap of the ring.
    send_sample('1);
    send_sample('0);
    send_sample('1);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample('1);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    for (int i = 0; i < 9; i++) send_sample('1);
    for (int i = 0; i < 6; i++) send_sample('0);
    // Let the output back up while samples keep coming.
    long_hold = 1'b1;
    for (int i = 0; i < 60; i++) send_sample(rand_sample());
    drain();
    repeat ($urandom_range(40, 20)) @(posedge clk_i);
    for (int i = 0; i < 1650; i++) send_sample(rand_sample());
    quiet_tail = 1'b1;
    for (int i = 0; i < 170; i++) send_sample(rand_sample());
    drain();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("** sliding_trimmed_mean_filter: PASSED **");
    end else begin
      $display("** sliding_trimmed_mean_filter: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/stmf_pkg.sv
rtl/stmf_if.sv
rtl/stmf_window_mem.sv
rtl/stmf_divider.sv
rtl/sliding_trimmed_mean_filter.sv
verif/sliding_trimmed_mean_filter_tb.sv
